// ===== rtl/core/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg: shared types and constants for the lightmap texel combiner
// Payload structures of both streams, lane configuration and fixed widths.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int BYTE_W      = 8;
    localparam int RGB_W       = 24;
    localparam int SCALE_W     = 16;
    localparam int STYLE_W     = 48;
    localparam int NUM_SAMPLES = 4;
    localparam int NUM_CH      = 3;
    localparam int PROD_W      = 24;   // byte times 8.8 scale
    localparam int CH_W        = 18;   // integer part of the largest sum
    localparam int NUM_W       = 26;   // channel times 255
    localparam int QUO_W       = 8;    // normalized byte
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;

    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'd255;
    localparam logic [NUM_W-1:0]  ALPHA_NUM = 26'd65025;   // 255 * 255

    typedef enum logic [2:0] {
        REG_STYLE_COUNT  = 3'd0,
        REG_STAIN_ENABLE = 3'd1,
        REG_MOD_SCALE    = 3'd2,
        REG_STYLE0_SCALE = 3'd3,
        REG_STYLE1_SCALE = 3'd4,
        REG_STYLE2_SCALE = 3'd5,
        REG_STYLE3_SCALE = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [RGB_W-1:0] sample0_rgb;
        logic [RGB_W-1:0] sample1_rgb;
        logic [RGB_W-1:0] sample2_rgb;
        logic [RGB_W-1:0] sample3_rgb;
        logic [RGB_W-1:0] stain_rgb;
        logic             last_texel;
    } t_texel;

    typedef struct packed {
        logic [BYTE_W-1:0] out_red;
        logic [BYTE_W-1:0] out_green;
        logic [BYTE_W-1:0] out_blue;
        logic [BYTE_W-1:0] out_alpha;
        logic              block_done;
    } t_result;

    // Lane settings; the user, not the block, keeps them stable while transactions are in flight.
    typedef struct packed {
        logic [NUM_SAMPLES-1:0] style_mask;
        logic                   stain_en;
        logic                   full_bright;
        logic [SCALE_W-1:0]     mod_scale;
    } t_lane_cfg;

    function automatic logic [PROD_W-1:0] mul_8x16(input logic [BYTE_W-1:0] a,
                                                   input logic [SCALE_W-1:0] b);
        return PROD_W'(a) * PROD_W'(b);
    endfunction

endpackage

// ===== rtl/core/ltc_stream_if.sv =====
// ----------------------------------------------------------------------------
// ltc_stream_if: valid/ready stream carrying one payload structure
// A transaction completes at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ltc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ltc_chan_lane.sv =====
// ----------------------------------------------------------------------------
// ltc_chan_lane: light combine for one color channel
// Stage one multiplies each enabled style byte by its scale and the stain byte
// by the modulate scale; stage two sums, stain-limits, truncates or forces 255.
// ----------------------------------------------------------------------------
module ltc_chan_lane #(
    parameter int MAX_STYLES = 4
) (
    input  logic                                              i_clk,
    input  logic                                              i_en_mul,
    input  logic                                              i_en_sum,
    input  ltc_pkg::t_lane_cfg                                i_cfg,
    input  logic [ltc_pkg::NUM_SAMPLES-1:0][ltc_pkg::BYTE_W-1:0]  i_sample,
    input  logic [ltc_pkg::NUM_SAMPLES-1:0][ltc_pkg::SCALE_W-1:0] i_scale,
    input  logic [ltc_pkg::BYTE_W-1:0]                        i_stain,
    output logic [ltc_pkg::CH_W-1:0]                          o_chan
);
    import ltc_pkg::*;

    localparam int SUM_W = PROD_W + $clog2(MAX_STYLES);

    logic [PROD_W-1:0] r_prod [MAX_STYLES];
    logic [PROD_W-1:0] r_lim;
    logic [CH_W-1:0]   r_chan;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_lim;
    logic [SUM_W-1:0]  w_clamped;

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            for (int s = 0; s < MAX_STYLES; s++) begin
                r_prod[s] <= i_cfg.style_mask[s] ? mul_8x16(i_sample[s], i_scale[s])
                                                 : '0;
            end
            r_lim <= mul_8x16(i_stain, i_cfg.mod_scale);
        end
    end

    always_comb begin
        w_sum = '0;
        for (int s = 0; s < MAX_STYLES; s++) begin
            w_sum = w_sum + SUM_W'(r_prod[s]);
        end
        w_lim     = SUM_W'(r_lim);
        w_clamped = (i_cfg.stain_en && (w_sum > w_lim)) ? w_lim : w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            if (i_cfg.full_bright) begin
                r_chan <= CH_W'(FULL_BYTE);
            end else begin
                r_chan <= CH_W'(w_clamped[SUM_W-1:8]);
            end
        end
    end

    assign o_chan = r_chan;

endmodule

// ===== rtl/core/ltc_div_lane.sv =====
// ----------------------------------------------------------------------------
// ltc_div_lane: pipelined restoring divider for one output byte
// One quotient bit per stage, most significant first. The quotient of a
// normalized channel always fits in a byte because the dividend is below
// 256 times the divisor. Without normalization the bypass byte is passed on.
// ----------------------------------------------------------------------------
module ltc_div_lane (
    input  logic                         i_clk,
    input  logic [ltc_pkg::QUO_W-1:0]    i_en,
    input  logic [ltc_pkg::NUM_W-1:0]    i_num,
    input  logic [ltc_pkg::CH_W-1:0]     i_den,
    input  logic                         i_norm,
    input  logic [ltc_pkg::BYTE_W-1:0]   i_byp,
    output logic [ltc_pkg::BYTE_W-1:0]   o_byte
);
    import ltc_pkg::*;

    logic [NUM_W-1:0]  r_rem  [QUO_W];
    logic [QUO_W-1:0]  r_quo  [QUO_W];
    logic [CH_W-1:0]   r_den  [QUO_W];
    logic              r_norm [QUO_W];
    logic [BYTE_W-1:0] r_byp  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [NUM_W-1:0] w_rem_in;
        logic [QUO_W-1:0] w_quo_in;
        logic [CH_W-1:0]  w_den_in;
        logic             w_norm_in;
        logic [BYTE_W-1:0] w_byp_in;
        logic [NUM_W-1:0] w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_num;
            assign w_quo_in  = '0;
            assign w_den_in  = i_den;
            assign w_norm_in = i_norm;
            assign w_byp_in  = i_byp;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_norm_in = r_norm[k-1];
            assign w_byp_in  = r_byp[k-1];
        end

        assign w_trial = NUM_W'(w_den_in) << (QUO_W - 1 - k);
        assign w_ge    = (w_rem_in >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k]  <= w_ge ? (w_rem_in - w_trial) : w_rem_in;
                r_quo[k]  <= {w_quo_in[QUO_W-2:0], w_ge};
                r_den[k]  <= w_den_in;
                r_norm[k] <= w_norm_in;
                r_byp[k]  <= w_byp_in;
            end
        end
    end

    assign o_byte = r_norm[QUO_W-1] ? r_quo[QUO_W-1] : r_byp[QUO_W-1];

endmodule

// ===== rtl/core/lightmap_texel_combine.sv =====
// ----------------------------------------------------------------------------
// lightmap_texel_combine: lightmap texel combine and brightness normalize
// Texels arrive on i_texel, one transaction per texel, carrying up to four
// style RGB samples and a stain RGB. Each RGBA result leaves on o_result.
// Settings are written over the APB port (64-bit data, register i at byte
// address 8*i); the user must write them only while no transaction is in
// flight, which the block does not enforce. Reads return the values. Three
// channel lanes multiply and sum the styles side by side, a merge stage takes
// the largest channel and forms the dividends, and four divider lanes (red,
// green, blue, alpha) produce one quotient bit per stage. A texel passes two
// combine stages, one merge stage and eight divider stages before its result
// is offered. Throughput is one texel per cycle whenever the receiver takes
// results. When o_result is stalled, results stay in the pipeline and empty
// stages still fill, so i_texel keeps accepting until every stage holds a
// texel. Reset empties the pipeline and restores the register defaults: one
// style, stains off, modulate 1.0 and all style scales 1.0.
// ----------------------------------------------------------------------------
module lightmap_texel_combine #(
    parameter int MAX_STYLES = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ltc_stream_if.sink                   i_texel,
    ltc_stream_if.source                 o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ltc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ltc_pkg::DATA_W-1:0]   pwdata,
    output logic [ltc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import ltc_pkg::*;

    localparam int STG_MUL  = 0;
    localparam int STG_SUM  = 1;
    localparam int STG_MRG  = 2;
    localparam int STG_DIV0 = 3;
    localparam int NSTG     = STG_DIV0 + QUO_W;
    localparam logic [STYLE_W-1:0] SCALE_ONE = 48'h0100_0100_0100;

    // ---------------- configuration registers ----------------
    logic [2:0]         r_style_count;
    logic               r_stain_en;
    logic [SCALE_W-1:0] r_mod_scale;
    logic [STYLE_W-1:0] r_style_scale [NUM_SAMPLES];
    logic [2:0]         w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style_count <= 3'd1;
            r_stain_en    <= 1'b0;
            r_mod_scale   <= 16'd256;
            for (int s = 0; s < NUM_SAMPLES; s++) begin
                r_style_scale[s] <= SCALE_ONE;
            end
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STYLE_COUNT:  r_style_count    <= pwdata[2:0];
                REG_STAIN_ENABLE: r_stain_en       <= pwdata[0];
                REG_MOD_SCALE:    r_mod_scale      <= pwdata[SCALE_W-1:0];
                REG_STYLE0_SCALE: r_style_scale[0] <= pwdata[STYLE_W-1:0];
                REG_STYLE1_SCALE: r_style_scale[1] <= pwdata[STYLE_W-1:0];
                REG_STYLE2_SCALE: r_style_scale[2] <= pwdata[STYLE_W-1:0];
                REG_STYLE3_SCALE: r_style_scale[3] <= pwdata[STYLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_STYLE_COUNT:  prdata = DATA_W'(r_style_count);
            REG_STAIN_ENABLE: prdata = DATA_W'(r_stain_en);
            REG_MOD_SCALE:    prdata = DATA_W'(r_mod_scale);
            REG_STYLE0_SCALE: prdata = DATA_W'(r_style_scale[0]);
            REG_STYLE1_SCALE: prdata = DATA_W'(r_style_scale[1]);
            REG_STYLE2_SCALE: prdata = DATA_W'(r_style_scale[2]);
            REG_STYLE3_SCALE: prdata = DATA_W'(r_style_scale[3]);
            default:          prdata = '0;
        endcase
    end

    // Style counts above the supported number saturate.
    logic [2:0] w_nsat;
    t_lane_cfg  w_cfg;

    assign w_nsat = (r_style_count > 3'(MAX_STYLES)) ? 3'(MAX_STYLES) : r_style_count;

    always_comb begin
        for (int s = 0; s < NUM_SAMPLES; s++) begin
            w_cfg.style_mask[s] = (3'(s) < w_nsat);
        end
        w_cfg.stain_en    = r_stain_en;
        w_cfg.full_bright = (w_nsat == 3'd0);
        w_cfg.mod_scale   = r_mod_scale;
    end

    // ---------------- pipeline flow control ----------------
    // A stage may load when any stage from it to the output is empty or the
    // receiver takes the result this cycle.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;
    logic            r_last [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_rdy
        assign w_rdy[k] = o_result.ready || !(&r_vld[NSTG-1:k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_texel.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_last[0] <= i_texel.data.last_texel;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    assign i_texel.ready = w_rdy[0];

    // ---------------- channel lanes ----------------
    logic [NUM_SAMPLES-1:0][RGB_W-1:0] w_samp;
    logic [CH_W-1:0]                   w_chan [NUM_CH];

    assign w_samp = {i_texel.data.sample3_rgb, i_texel.data.sample2_rgb,
                     i_texel.data.sample1_rgb, i_texel.data.sample0_rgb};

    for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
        logic [NUM_SAMPLES-1:0][BYTE_W-1:0]  w_bytes;
        logic [NUM_SAMPLES-1:0][SCALE_W-1:0] w_scales;

        for (genvar s = 0; s < NUM_SAMPLES; s++) begin : g_style
            assign w_bytes[s]  = w_samp[s][BYTE_W*c +: BYTE_W];
            assign w_scales[s] = r_style_scale[s][SCALE_W*c +: SCALE_W];
        end

        ltc_chan_lane #(
            .MAX_STYLES (MAX_STYLES)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en_mul (w_rdy[STG_MUL]),
            .i_en_sum (w_rdy[STG_SUM]),
            .i_cfg    (w_cfg),
            .i_sample (w_bytes),
            .i_scale  (w_scales),
            .i_stain  (i_texel.data.stain_rgb[BYTE_W*c +: BYTE_W]),
            .o_chan   (w_chan[c])
        );
    end

    // ---------------- merge stage ----------------
    logic [CH_W-1:0]   w_max;
    logic [NUM_W-1:0]  r_num [NUM_CH];
    logic [BYTE_W-1:0] r_byp [NUM_CH];
    logic [CH_W-1:0]   r_den;
    logic              r_norm;

    always_comb begin
        w_max = (w_chan[0] > w_chan[1]) ? w_chan[0] : w_chan[1];
        if (w_chan[2] > w_max) begin
            w_max = w_chan[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[STG_MRG]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_num[c] <= (NUM_W'(w_chan[c]) << 8) - NUM_W'(w_chan[c]);
                r_byp[c] <= w_chan[c][BYTE_W-1:0];
            end
            r_den  <= w_max;
            r_norm <= (w_max > CH_W'(FULL_BYTE));
        end
    end

    // ---------------- divider lanes ----------------
    logic [BYTE_W-1:0] w_out [NUM_CH+1];

    for (genvar c = 0; c <= NUM_CH; c++) begin : g_div
        logic [NUM_W-1:0]  w_num;
        logic [BYTE_W-1:0] w_byp;

        if (c < NUM_CH) begin : g_color
            assign w_num = r_num[c];
            assign w_byp = r_byp[c];
        end else begin : g_alpha
            assign w_num = ALPHA_NUM;
            assign w_byp = FULL_BYTE;
        end

        ltc_div_lane u_div (
            .i_clk  (i_clk),
            .i_en   (w_rdy[NSTG-1:STG_DIV0]),
            .i_num  (w_num),
            .i_den  (r_den),
            .i_norm (r_norm),
            .i_byp  (w_byp),
            .o_byte (w_out[c])
        );
    end

    assign o_result.valid           = r_vld[NSTG-1];
    assign o_result.data.out_red    = w_out[0];
    assign o_result.data.out_green  = w_out[1];
    assign o_result.data.out_blue   = w_out[2];
    assign o_result.data.out_alpha  = w_out[NUM_CH];
    assign o_result.data.block_done = r_last[NSTG-1];

    // ---------------- assertions ----------------
    // A stalled result holds its value until the receiver takes it.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |=>
            o_result.valid && $stable(o_result.data))
        else $error("result changed while stalled");

    // A normalized result always has its brightest channel at full scale.
    a_norm_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.data.out_alpha != FULL_BYTE)) |->
            (o_result.data.out_red == FULL_BYTE) ||
            (o_result.data.out_green == FULL_BYTE) ||
            (o_result.data.out_blue == FULL_BYTE))
        else $error("normalized result without a full channel");

    // Input is refused only when every stage holds a texel.
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_texel.ready |-> (&r_vld) && !o_result.ready)
        else $error("input stalled with room in the pipeline");

    // An accepted texel always lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_texel.valid && i_texel.ready) |=> r_vld[0])
        else $error("accepted texel lost at pipeline entry");

endmodule

// ===== verif/tb_lightmap_texel_combine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lightmap_texel_combine: self-checking bench for the lightmap texel combiner
// Loads settings over APB while the pipeline is empty and reads them back.
// It then streams a table of corner-case texels followed by randomized texels
// under random stalls on both streams, except in one phase. Every result is
// checked against a typed value or an in-bench combine/stain/normalize model.
// ----------------------------------------------------------------------------
module tb_lightmap_texel_combine;
    import ltc_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 6;
    localparam int          PIPE_LATENCY  = 11;
    localparam int          RAND_PHASES   = 7;
    localparam int          PHASE_ITEMS   = 250;
    localparam int          STEADY_PHASE  = 3;
    localparam int          IDLE_PERCENT  = 21;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam logic [2:0]  REG_UNMAPPED  = 3'd7;
    localparam logic [STYLE_W-1:0] SCALE_ONE  = 48'h0100_0100_0100;
    localparam logic [STYLE_W-1:0] SCALE_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [STYLE_W-1:0] SCALE_ZERO = 48'h0000_0000_0000;

    typedef struct packed {
        logic [2:0]                           style_count;
        logic                                 stain_en;
        logic [SCALE_W-1:0]                   mod_scale;
        logic [NUM_SAMPLES-1:0][STYLE_W-1:0]  style_scale;
    } t_settings;

    typedef struct {
        t_settings cfg;
        t_texel    tx;
        bit        known;
        t_result   want;
    } t_corner;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    ltc_stream_if #(.T(t_texel))  texel_if ();
    ltc_stream_if #(.T(t_result)) result_if ();

    t_settings  active_cfg;
    t_result    pending_rgba [$];
    t_corner    corner_rows [$];
    bit         use_typed;
    t_result    typed_result;
    bit         steady;
    int         mismatch_count;
    int         cycle_count;

    lightmap_texel_combine #(
        .MAX_STYLES (NUM_SAMPLES)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_texel  (texel_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic t_result combine_texel(input t_texel tx, input t_settings s);
        logic [RGB_W-1:0] smp [NUM_SAMPLES];
        logic [NUM_W-1:0] acc;
        logic [NUM_W-1:0] lim;
        logic [CH_W-1:0]  chn [NUM_CH];
        logic [CH_W-1:0]  peak;
        int unsigned      n;
        int               c;
        int               i;
        t_result          r;
        smp[0] = tx.sample0_rgb;
        smp[1] = tx.sample1_rgb;
        smp[2] = tx.sample2_rgb;
        smp[3] = tx.sample3_rgb;
        // Counts above the number of sample slots behave like the full count.
        n = (s.style_count > NUM_SAMPLES) ? NUM_SAMPLES : s.style_count;
        for (c = 0; c < NUM_CH; c++) begin
            if (n == 0) begin
                chn[c] = CH_W'(FULL_BYTE);
            end else begin
                acc = '0;
                for (i = 0; i < n; i++) begin
                    acc += NUM_W'(smp[i][8*c +: 8]) * NUM_W'(s.style_scale[i][16*c +: 16]);
                end
                if (s.stain_en) begin
                    lim = NUM_W'(tx.stain_rgb[8*c +: 8]) * NUM_W'(s.mod_scale);
                    if (acc > lim) begin
                        acc = lim;
                    end
                end
                chn[c] = acc[NUM_W-1:8];
            end
        end
        peak = (chn[0] > chn[1]) ? chn[0] : chn[1];
        if (chn[2] > peak) begin
            peak = chn[2];
        end
        r.out_alpha = FULL_BYTE;
        if (peak > CH_W'(FULL_BYTE)) begin
            for (c = 0; c < NUM_CH; c++) begin
                chn[c] = CH_W'((NUM_W'(chn[c]) * NUM_W'(FULL_BYTE)) / NUM_W'(peak));
            end
            r.out_alpha = BYTE_W'(ALPHA_NUM / NUM_W'(peak));
        end
        r.out_red    = chn[0][BYTE_W-1:0];
        r.out_green  = chn[1][BYTE_W-1:0];
        r.out_blue   = chn[2][BYTE_W-1:0];
        r.block_done = tx.last_texel;
        return r;
    endfunction

    function automatic t_settings make_settings(input logic [2:0] cnt, input logic stain,
                                                input logic [SCALE_W-1:0] modulate,
                                                input logic [STYLE_W-1:0] sc0,
                                                input logic [STYLE_W-1:0] sc1,
                                                input logic [STYLE_W-1:0] sc2,
                                                input logic [STYLE_W-1:0] sc3);
        t_settings s;
        s.style_count    = cnt;
        s.stain_en       = stain;
        s.mod_scale      = modulate;
        s.style_scale[0] = sc0;
        s.style_scale[1] = sc1;
        s.style_scale[2] = sc2;
        s.style_scale[3] = sc3;
        return s;
    endfunction

    function automatic t_texel make_texel(input logic [RGB_W-1:0] s0, input logic [RGB_W-1:0] s1,
                                          input logic [RGB_W-1:0] s2, input logic [RGB_W-1:0] s3,
                                          input logic [RGB_W-1:0] stain, input logic last);
        t_texel t;
        t.sample0_rgb = s0;
        t.sample1_rgb = s1;
        t.sample2_rgb = s2;
        t.sample3_rgb = s3;
        t.stain_rgb   = stain;
        t.last_texel  = last;
        return t;
    endfunction

    function automatic t_result make_rgba(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] a,
                                          input logic done);
        t_result res;
        res.out_red    = r;
        res.out_green  = g;
        res.out_blue   = b;
        res.out_alpha  = a;
        res.block_done = done;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] reg_image(input t_settings s, input t_reg_idx idx);
        logic [DATA_W-1:0] v;
        case (idx)
            REG_STYLE_COUNT:  v = DATA_W'(s.style_count);
            REG_STAIN_ENABLE: v = DATA_W'(s.stain_en);
            REG_MOD_SCALE:    v = DATA_W'(s.mod_scale);
            REG_STYLE0_SCALE: v = DATA_W'(s.style_scale[0]);
            REG_STYLE1_SCALE: v = DATA_W'(s.style_scale[1]);
            REG_STYLE2_SCALE: v = DATA_W'(s.style_scale[2]);
            REG_STYLE3_SCALE: v = DATA_W'(s.style_scale[3]);
            default:          v = '0;
        endcase
        return v;
    endfunction

    // Scales lean toward zero, unity, full range and values near unity.
    function automatic logic [SCALE_W-1:0] pick_scale();
        logic [SCALE_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 16'h0100;
            2:       v = 16'hFFFF;
            3:       v = SCALE_W'($urandom_range(0, 16'h0200));
            default: v = SCALE_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic t_settings rand_settings();
        t_settings s;
        int        i;
        int        c;
        if ($urandom_range(0, 9) == 0) begin
            s.style_count = 3'($urandom_range(0, 7));
        end else begin
            s.style_count = 3'($urandom_range(1, NUM_SAMPLES));
        end
        s.stain_en  = 1'($urandom_range(0, 1));
        s.mod_scale = pick_scale();
        for (i = 0; i < NUM_SAMPLES; i++) begin
            for (c = 0; c < NUM_CH; c++) begin
                s.style_scale[i][16*c +: 16] = pick_scale();
            end
        end
        return s;
    endfunction

    function automatic logic [RGB_W-1:0] rand_rgb();
        logic [RGB_W-1:0] v;
        int               c;
        for (c = 0; c < NUM_CH; c++) begin
            case ($urandom_range(0, 9))
                0:       v[8*c +: 8] = 8'h00;
                1:       v[8*c +: 8] = 8'hFF;
                default: v[8*c +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return v;
    endfunction

    task automatic add_row(input t_settings cfg, input t_texel tx, input bit known,
                           input t_result want);
        t_corner row;
        row.cfg   = cfg;
        row.tx    = tx;
        row.known = known;
        row.want  = want;
        corner_rows.push_back(row);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] idx,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = ADDR_W'(idx) << 3;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Writes every register, pokes the address past the last one, then reads
    // all of them back; the stray write must leave everything untouched.
    task automatic load_settings(input t_settings s);
        logic [DATA_W-1:0] rd;
        t_reg_idx          r;
        active_cfg = s;
        r = r.first();
        repeat (r.num()) begin
            apb_access(1'b1, r, reg_image(s, r), rd);
            r = r.next();
        end
        apb_access(1'b1, REG_UNMAPPED, '1, rd);
        r = r.first();
        repeat (r.num()) begin
            apb_access(1'b0, r, '0, rd);
            if (rd !== reg_image(s, r)) begin
                $error("%s readback mismatch: expected 0x%0h, actual 0x%0h",
                       r.name(), reg_image(s, r), rd);
                mismatch_count++;
            end
            r = r.next();
        end
    endtask

    task automatic wait_results_drained();
        texel_if.valid = 1'b0;
        while (pending_rgba.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic send_texel(input t_texel tx, input bit typed, input t_result want);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            texel_if.valid = 1'b0;
            @(negedge i_clk);
        end
        texel_if.valid = 1'b1;
        texel_if.data  = tx;
        use_typed      = typed;
        typed_result   = want;
        do @(posedge i_clk); while (!texel_if.ready);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        result_if.ready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (texel_if.valid && texel_if.ready) begin
                pending_rgba.push_back(use_typed ? typed_result
                                                 : combine_texel(texel_if.data, active_cfg));
            end
            if (result_if.valid && result_if.ready) begin
                got = result_if.data;
                if (pending_rgba.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    mismatch_count++;
                end else begin
                    want = pending_rgba.pop_front();
                    if (got.out_red !== want.out_red) begin
                        $error("out_red mismatch: expected %0d, actual %0d",
                               want.out_red, got.out_red);
                        mismatch_count++;
                    end
                    if (got.out_green !== want.out_green) begin
                        $error("out_green mismatch: expected %0d, actual %0d",
                               want.out_green, got.out_green);
                        mismatch_count++;
                    end
                    if (got.out_blue !== want.out_blue) begin
                        $error("out_blue mismatch: expected %0d, actual %0d",
                               want.out_blue, got.out_blue);
                        mismatch_count++;
                    end
                    if (got.out_alpha !== want.out_alpha) begin
                        $error("out_alpha mismatch: expected %0d, actual %0d",
                               want.out_alpha, got.out_alpha);
                        mismatch_count++;
                    end
                    if (got.block_done !== want.block_done) begin
                        $error("block_done mismatch: expected %0d, actual %0d",
                               want.block_done, got.block_done);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_settings cfg_default;
        t_settings cfg_dark;
        t_settings cfg_sat;
        t_settings cfg_four;
        t_settings cfg_hot;
        t_settings cfg_black;
        t_settings cfg_stain;
        t_settings cfg_stain_hot;
        t_settings cfg_stain_zero;
        t_settings cfg_edge;
        t_settings cfg_over;
        t_settings cfg_blue2;
        t_settings cfg_pair;
        t_settings cfg_trio;
        t_settings cur;
        t_corner   row;
        int        phase;
        int        k;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        texel_if.valid = 1'b0;
        texel_if.data  = '0;
        result_if.ready = 1'b0;
        use_typed      = 1'b0;
        typed_result   = '0;
        steady         = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;

        cfg_default    = make_settings(3'd1, 1'b0, 16'h0100,
                                       SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE);
        cfg_dark       = make_settings(3'd0, 1'b1, 16'hFFFF,
                                       SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX);
        cfg_sat        = make_settings(3'd7, 1'b0, 16'h0100,
                                       SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE);
        cfg_four       = make_settings(3'd4, 1'b0, 16'h0100,
                                       SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE);
        cfg_hot        = make_settings(3'd4, 1'b0, 16'h0100,
                                       SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX);
        cfg_black      = make_settings(3'd4, 1'b0, 16'h0100,
                                       SCALE_ZERO, SCALE_ZERO, SCALE_ZERO, SCALE_ZERO);
        cfg_stain      = make_settings(3'd1, 1'b1, 16'h0100,
                                       SCALE_ONE, SCALE_ONE, SCALE_ONE, SCALE_ONE);
        cfg_stain_hot  = make_settings(3'd4, 1'b1, 16'hFFFF,
                                       SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX);
        cfg_stain_zero = make_settings(3'd4, 1'b1, 16'h0000,
                                       SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX);
        cfg_edge       = make_settings(3'd1, 1'b0, 16'h0100,
                                       48'h0100_0100_0101, SCALE_ONE, SCALE_ONE, SCALE_ONE);
        cfg_over       = make_settings(3'd1, 1'b0, 16'h0100,
                                       48'h0100_0100_0102, SCALE_ONE, SCALE_ONE, SCALE_ONE);
        cfg_blue2      = make_settings(3'd1, 1'b0, 16'h0100,
                                       48'h0200_0100_0100, SCALE_ONE, SCALE_ONE, SCALE_ONE);
        cfg_pair       = make_settings(3'd2, 1'b0, 16'h0100,
                                       48'h0080_0200_0100, 48'h0300_0040_0180,
                                       SCALE_ONE, SCALE_ONE);
        cfg_trio       = make_settings(3'd3, 1'b1, 16'h0180,
                                       48'h1234_0FFF_00C0, 48'hFFFF_0001_0100,
                                       48'h0100_8000_0040, SCALE_MAX);

        // Reset values first, then no styles, an oversized count, the extremes
        // of scales and stains, and the boundary where normalization starts.
        add_row(cfg_default, make_texel(0, 0, 0, 0, 0, 1'b0), 1,
                make_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
        add_row(cfg_default, make_texel(24'hFFFFFF, 0, 0, 0, 0, 1'b1), 1,
                make_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        add_row(cfg_default, make_texel(24'h102030, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                        24'hFFFFFF, 1'b0), 1,
                make_rgba(8'h30, 8'h20, 8'h10, 8'd255, 1'b0));
        add_row(cfg_dark, make_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                     24'h000000, 1'b0), 1,
                make_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
        add_row(cfg_dark, make_texel(0, 0, 0, 0, 0, 1'b1), 1,
                make_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        add_row(cfg_sat, make_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1'b0), 1,
                make_rgba(8'd255, 8'd255, 8'd255, 8'd63, 1'b0));
        add_row(cfg_four, make_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1'b0), 1,
                make_rgba(8'd255, 8'd255, 8'd255, 8'd63, 1'b0));
        add_row(cfg_four, make_texel(0, 0, 0, 24'h8040C0, 0, 1'b1), 0, '0);
        add_row(cfg_hot, make_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1'b1), 1,
                make_rgba(8'd255, 8'd255, 8'd255, 8'd0, 1'b1));
        add_row(cfg_black, make_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1'b0),
                1, make_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
        add_row(cfg_stain, make_texel(24'hFFFFFF, 0, 0, 0, 24'h000000, 1'b0), 1,
                make_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
        add_row(cfg_stain, make_texel(24'hFFFFFF, 0, 0, 0, 24'hFFFFFF, 1'b0), 1,
                make_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
        add_row(cfg_stain, make_texel(24'hFFFFFF, 0, 0, 0, 24'h00FF80, 1'b1), 1,
                make_rgba(8'h80, 8'hFF, 8'h00, 8'd255, 1'b1));
        add_row(cfg_stain_hot, make_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                          24'hFFFFFF, 1'b0), 1,
                make_rgba(8'd255, 8'd255, 8'd255, 8'd0, 1'b0));
        add_row(cfg_stain_zero, make_texel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                           24'hFFFFFF, 1'b0), 1,
                make_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
        add_row(cfg_edge, make_texel(24'h0000FF, 0, 0, 0, 0, 1'b0), 1,
                make_rgba(8'd255, 8'd0, 8'd0, 8'd255, 1'b0));
        add_row(cfg_over, make_texel(24'h0000FF, 0, 0, 0, 0, 1'b1), 1,
                make_rgba(8'd255, 8'd0, 8'd0, 8'd254, 1'b1));
        add_row(cfg_blue2, make_texel(24'h80FF40, 0, 0, 0, 0, 1'b0), 0, '0);
        add_row(cfg_pair, make_texel(24'h406080, 24'h20A0FF, 24'hFFFFFF, 24'hFFFFFF, 0, 1'b0),
                0, '0);
        add_row(cfg_trio, make_texel(24'hC08040, 24'h7F01FE, 24'h33CC99, 24'hFFFFFF,
                                     24'h80FF20, 1'b1), 0, '0);

        active_cfg = cfg_default;
        cur        = cfg_default;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (corner_rows[k]) begin
            row = corner_rows[k];
            if (row.cfg != cur) begin
                wait_results_drained();
                load_settings(row.cfg);
                cur = row.cfg;
            end
            send_texel(row.tx, row.known, row.want);
        end

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            wait_results_drained();
            load_settings(rand_settings());
            steady = (phase == STEADY_PHASE);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // Halfway through a phase the sender holds off until the
                // pipeline has emptied, then restarts from cold.
                if (k == PHASE_ITEMS / 2) begin
                    wait_results_drained();
                end
                send_texel(make_texel(rand_rgb(), rand_rgb(), rand_rgb(), rand_rgb(),
                                      rand_rgb(), 1'($urandom_range(0, 7) == 0)), 0, '0);
            end
            steady = 1'b0;
        end

        wait_results_drained();
        repeat (3 * PIPE_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && pending_rgba.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ltc_pkg.sv
rtl/core/ltc_stream_if.sv
rtl/core/ltc_chan_lane.sv
rtl/core/ltc_div_lane.sv
rtl/core/lightmap_texel_combine.sv
verif/tb_lightmap_texel_combine.sv
